// ----- rtl/wspid_pkg.sv -----
// Package for the wheel speed PID / H-bridge unit.
// Field widths, register reset values, config register indexes, divide-by-ten constant.
// No dependencies.
package wspid_pkg;

    localparam int SPEED_W   = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int GAIN_W    = 8;
    localparam int ILIM_W    = 15;
    localparam int DUTY_W    = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 8'd12;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 8'd19;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 8'd5;
    localparam logic [ILIM_W-1:0]  INTEG_LIM_RST  = 15'd1000;
    localparam logic [DUTY_W-1:0]  DUTY_LIM_RST   = 12'd900;
    localparam logic [SPEED_W-1:0] BRAKE_THR_RST  = 16'hFFCE; // -50

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SH for x < 2**26
    localparam int              RECIP10_SH = 27;
    localparam logic [23:0]     RECIP10    = 24'd13421773;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INTEG_GAIN = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_INTEG_LIM  = 3'd3,
        CFG_DUTY_LIM   = 3'd4,
        CFG_BRAKE_THR  = 3'd5
    } t_cfg_idx;

endpackage

// ----- rtl/wheel_speed_pid_hbridge_unit.sv -----
// Channel   Dir  Group                            Beat contents
// s_axis    in   i_s_tvalid/o_s_tready/i_s_tdata  target_speed, measured_speed
// m_axis    out  o_m_tvalid/i_m_tready/o_m_tdata  forward_duty, reverse_duty, braking
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Four register stages: input, error/integral/products, divide by ten, sum/clamp/output.
// One beat per cycle sustained unless i_m_tready stalls the output.
// Integral and previous error update as a beat leaves the input stage.
// Synchronous active-low reset clears config to defaults, state and valids.
// Each stage advances when the one after it is empty or moving, so bubbles collapse.
// Depends on wspid_pkg.
module wheel_speed_pid_hbridge_unit
    import wspid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [15:0] target_speed, [31:16] measured_speed
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [11:0] forward_duty, [23:12] reverse_duty,
                                              // [24] braking, [31:25] zero
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // config
    logic [GAIN_W-1:0]         r_prop_gain;
    logic [GAIN_W-1:0]         r_integ_gain;
    logic [GAIN_W-1:0]         r_deriv_gain;
    logic [ILIM_W-1:0]         r_integ_lim;
    logic [DUTY_W-1:0]         r_duty_lim;
    logic signed [SPEED_W-1:0] r_brake_thr;

    // state
    logic signed [SPEED_W-1:0] r_err_sum;
    logic signed [ERR_W-1:0]   r_prev_err;

    // pipeline
    logic                      r_v0, r_v1, r_v2, r_v3;
    logic                      w_rdy0, w_rdy1, w_rdy2, w_rdy3;
    logic signed [SPEED_W-1:0] r_in_tgt, r_in_meas;
    logic signed [24:0]        r_a_p, r_b_p;
    logic signed [25:0]        r_a_d, r_b_d;
    logic [22:0]               r_a_ip;
    logic                      r_a_ineg;
    logic                      r_a_brake, r_b_brake, r_out_brake;
    logic signed [20:0]        r_b_iq;
    logic [DUTY_W-1:0]         r_out_fwd, r_out_rev;

    // stage 1 logic
    logic signed [ERR_W-1:0]   w_err;
    logic signed [17:0]        w_sum_raw, w_ilim;
    logic signed [SPEED_W-1:0] n_err_sum;
    logic                      w_brake;
    logic signed [24:0]        w_p;
    logic signed [17:0]        w_diff;
    logic signed [25:0]        w_d;
    logic [ILIM_W-1:0]         w_sum_mag;
    logic [22:0]               w_ip;

    // stage 2 logic
    logic [46:0]               w_recip_prod;
    logic [19:0]               w_q;
    logic signed [20:0]        w_iq;

    // stage 3 logic
    logic signed [27:0]        w_total, w_dlim;
    logic signed [DUTY_W:0]    w_drive;
    logic [DUTY_W-1:0]         n_fwd, n_rev;

    assign w_rdy3 = !r_v3 || i_m_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;

    assign o_s_tready  = w_rdy0;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_v3;
    assign o_m_tdata   = {7'd0, r_out_brake, r_out_rev, r_out_fwd};

    // stage 1: error, clamped integral, gain products
    always_comb begin
        w_err     = ERR_W'(r_in_tgt) - ERR_W'(r_in_meas);
        w_sum_raw = 18'(r_err_sum) + 18'(w_err);
        w_ilim    = $signed({3'b000, r_integ_lim});
        if (w_sum_raw > w_ilim) begin
            n_err_sum = SPEED_W'(w_ilim);
        end else if (w_sum_raw < -w_ilim) begin
            n_err_sum = SPEED_W'(-w_ilim);
        end else begin
            n_err_sum = SPEED_W'(w_sum_raw);
        end
        w_brake   = !(w_err > ERR_W'(r_brake_thr));
        w_p       = $signed({17'd0, r_prop_gain}) * 25'(w_err);
        w_diff    = 18'(w_err) - 18'(r_prev_err);
        w_d       = $signed({18'd0, r_deriv_gain}) * 26'(w_diff);
        w_sum_mag = n_err_sum[SPEED_W-1] ? ILIM_W'(-n_err_sum) : n_err_sum[ILIM_W-1:0];
        w_ip      = 23'(r_integ_gain) * 23'(w_sum_mag);
    end

    // stage 2: divide magnitude by ten, restore sign (truncates toward zero)
    always_comb begin
        w_recip_prod = 47'(r_a_ip) * 47'(RECIP10);
        w_q          = w_recip_prod[RECIP10_SH+19:RECIP10_SH];
        w_iq         = r_a_ineg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    end

    // stage 3: sum, clamp (braking forces full reverse), split into bridge legs
    always_comb begin
        w_total = 28'(r_b_p) + 28'(r_b_iq) + 28'(r_b_d);
        w_dlim  = $signed({16'd0, r_duty_lim});
        if (r_b_brake || w_total < -w_dlim) begin
            w_drive = -$signed({1'b0, r_duty_lim});
        end else if (w_total > w_dlim) begin
            w_drive = $signed({1'b0, r_duty_lim});
        end else begin
            w_drive = (DUTY_W+1)'(w_total);
        end
        if (w_drive[DUTY_W]) begin
            n_fwd = '0;
            n_rev = DUTY_W'(-w_drive);
        end else begin
            n_fwd = w_drive[DUTY_W-1:0];
            n_rev = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
            r_integ_lim  <= INTEG_LIM_RST;
            r_duty_lim   <= DUTY_LIM_RST;
            r_brake_thr  <= BRAKE_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: r_integ_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN: r_deriv_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIM:  r_integ_lim  <= i_cfg_data[ILIM_W-1:0];
                CFG_DUTY_LIM:   r_duty_lim   <= i_cfg_data[DUTY_W-1:0];
                CFG_BRAKE_THR:  r_brake_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_err_sum  <= '0;
            r_prev_err <= '0;
        end else begin
            if (w_rdy0) r_v0 <= i_s_tvalid;
            if (w_rdy1) r_v1 <= r_v0;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy1 && r_v0) begin
                r_err_sum  <= n_err_sum;
                r_prev_err <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_in_tgt  <= i_s_tdata[15:0];
            r_in_meas <= i_s_tdata[31:16];
        end
        if (w_rdy1) begin
            r_a_p     <= w_p;
            r_a_d     <= w_d;
            r_a_ip    <= w_ip;
            r_a_ineg  <= n_err_sum[SPEED_W-1];
            r_a_brake <= w_brake;
        end
        if (w_rdy2) begin
            r_b_p     <= r_a_p;
            r_b_d     <= r_a_d;
            r_b_iq    <= w_iq;
            r_b_brake <= r_a_brake;
        end
        if (w_rdy3) begin
            r_out_fwd   <= n_fwd;
            r_out_rev   <= n_rev;
            r_out_brake <= r_b_brake;
        end
    end

endmodule

// ----- rtl/wspid_chk.sv -----
// Port-level checker for wheel_speed_pid_hbridge_unit, attached by bind.
// Depends on wspid_pkg.
module wspid_chk
    import wspid_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [M_TDATA_W-1:0] o_m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result beat changed while stalled");

    // only one bridge leg driven at a time
    a_one_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[11:0] == 12'd0 || o_m_tdata[23:12] == 12'd0))
        else $error("both bridge legs nonzero");

    // braking never drives forward
    a_brake_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[24] |-> o_m_tdata[11:0] == 12'd0)
        else $error("forward duty while braking");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:25] == 7'd0)
        else $error("nonzero pad bits");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind wheel_speed_pid_hbridge_unit wspid_chk u_wspid_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
